// ===== hw/rtl/lltc_pkg.sv =====
// ----------------------------------------------------------------------------
// lltc_pkg
// Shared types and constants for the LCD line timing controller.
// ----------------------------------------------------------------------------
package lltc_pkg;

  localparam int unsigned LINE_W    = 8;
  localparam int unsigned RESIDUE_W = 16;
  localparam int unsigned DOT_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned IEN_W     = 4;

  // Bit positions in status_irq_enables
  localparam int unsigned IEN_HBLANK = 0;
  localparam int unsigned IEN_VBLANK = 1;
  localparam int unsigned IEN_SCAN   = 2;
  localparam int unsigned IEN_MATCH  = 3;

  // Phase and status mode share one encoding
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LCD_ENABLE   = 2'd0,
    REG_LINE_COMPARE = 2'd1,
    REG_IRQ_ENABLES  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    mode_e                phase;
    logic [RESIDUE_W-1:0] residue;
    logic [LINE_W-1:0]    line;
    mode_e                mode;
    logic                 match;
  } lltc_state_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    mode_e             reported_mode;
    logic              line_match_flag;
    logic              vblank_irq;
    logic              status_irq;
    logic              sprite_scan_pulse;
    logic              line_render_pulse;
    logic              frame_done;
  } lltc_result_t;

endpackage

// ===== hw/rtl/lltc_step.sv =====
// ----------------------------------------------------------------------------
// lltc_step
// Next-state and result logic for one dot-count transaction.
// ----------------------------------------------------------------------------
module lltc_step import lltc_pkg::*; #(
  parameter int unsigned LINE_DOTS     = 456,
  parameter int unsigned SCAN_DOTS     = 80,
  parameter int unsigned DRAW_DOTS     = 172,
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned TOTAL_LINES   = 154
) (
  input  lltc_state_t          cur_i,
  input  logic [DOT_W-1:0]     dot_i,
  input  logic                 lcd_en_i,
  input  logic [LINE_W-1:0]    line_cmp_i,
  input  logic [IEN_W-1:0]     irq_en_i,
  output lltc_state_t          nxt_o,
  output lltc_result_t         res_o
);

  localparam int unsigned SUM_W = RESIDUE_W + 1;
  localparam int unsigned HBLANK_DOTS =
    (SCAN_DOTS + DRAW_DOTS >= LINE_DOTS) ? 0 : LINE_DOTS - SCAN_DOTS - DRAW_DOTS;

  localparam logic [SUM_W-1:0]  SCAN_NEED   = SUM_W'(SCAN_DOTS);
  localparam logic [SUM_W-1:0]  DRAW_NEED   = SUM_W'(DRAW_DOTS);
  localparam logic [SUM_W-1:0]  HBLANK_NEED = SUM_W'(HBLANK_DOTS);
  localparam logic [SUM_W-1:0]  LINE_NEED   = SUM_W'(LINE_DOTS);
  localparam logic [LINE_W-1:0] VIS_LINE    = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] TOT_LINE    = LINE_W'(TOTAL_LINES);

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rem;
  logic [LINE_W-1:0] line_inc;
  logic              match_inc;
  logic              match_zero;
  lltc_state_t       nxt;
  logic              stat, vb, scan_p, render_p, frame_p;

  assign sum        = {1'b0, cur_i.residue} + SUM_W'(dot_i);
  assign line_inc   = cur_i.line + LINE_W'(1);
  assign match_inc  = (line_inc == line_cmp_i);
  assign match_zero = (line_cmp_i == '0);

  always_comb begin
    nxt      = cur_i;
    rem      = sum;
    stat     = 1'b0;
    vb       = 1'b0;
    scan_p   = 1'b0;
    render_p = 1'b0;
    frame_p  = 1'b0;
    if (!lcd_en_i) begin
      // held at line zero; parked v-blank at line zero is left alone
      if (cur_i.line != '0 || cur_i.phase != MODE_VBLANK) begin
        nxt.line    = '0;
        nxt.residue = '0;
        nxt.phase   = MODE_HBLANK;
      end
    end else begin
      case (cur_i.phase)
        MODE_SCAN: begin
          if (sum >= SCAN_NEED) begin
            rem       = sum - SCAN_NEED;
            scan_p    = 1'b1;
            nxt.phase = MODE_DRAW;
            nxt.mode  = MODE_DRAW;
          end
        end
        MODE_DRAW: begin
          if (sum >= DRAW_NEED) begin
            rem       = sum - DRAW_NEED;
            render_p  = (cur_i.line < VIS_LINE);
            nxt.phase = MODE_HBLANK;
            nxt.mode  = MODE_HBLANK;
            stat      = irq_en_i[IEN_HBLANK];
          end
        end
        MODE_HBLANK: begin
          if (sum >= HBLANK_NEED) begin
            rem       = sum - HBLANK_NEED;
            nxt.line  = line_inc;
            nxt.match = match_inc;
            if (line_inc == VIS_LINE) begin
              nxt.phase = MODE_VBLANK;
              nxt.mode  = MODE_VBLANK;
              vb        = 1'b1;
              frame_p   = 1'b1;
              stat      = (match_inc & irq_en_i[IEN_MATCH]) | irq_en_i[IEN_VBLANK];
            end else begin
              nxt.phase = MODE_SCAN;
              nxt.mode  = MODE_SCAN;
              stat      = (match_inc & irq_en_i[IEN_MATCH]) | irq_en_i[IEN_SCAN];
            end
          end
        end
        default: begin
          if (sum >= LINE_NEED) begin
            rem = sum - LINE_NEED;
            if (line_inc >= TOT_LINE) begin
              // end of frame: compared at the wrapped count and again at zero
              nxt.line  = '0;
              nxt.match = match_zero;
              nxt.phase = MODE_SCAN;
              nxt.mode  = MODE_SCAN;
              stat      = ((match_inc | match_zero) & irq_en_i[IEN_MATCH])
                          | irq_en_i[IEN_SCAN];
            end else begin
              nxt.line  = line_inc;
              nxt.match = match_inc;
              stat      = match_inc & irq_en_i[IEN_MATCH];
            end
          end
        end
      endcase
      nxt.residue = rem[SUM_W-1] ? '1 : rem[RESIDUE_W-1:0];
    end
  end

  assign nxt_o = nxt;

  assign res_o.line_number       = nxt.line;
  assign res_o.reported_mode     = nxt.mode;
  assign res_o.line_match_flag   = nxt.match;
  assign res_o.vblank_irq        = vb;
  assign res_o.status_irq        = stat;
  assign res_o.sprite_scan_pulse = scan_p;
  assign res_o.line_render_pulse = render_p;
  assign res_o.frame_done        = frame_p;

endmodule

// ===== hw/rtl/lcd_line_timing_controller.sv =====
// ----------------------------------------------------------------------------
// lcd_line_timing_controller
// Display line timer: steps OAM scan, drawing, h-blank and v-blank phases
// from dot counts and raises status and v-blank interrupts.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, dot_count_i       | sink
//  out     | out_valid_o, out_ready_i, result fields   | source
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data | sink
//
//  An input register holds each tick; one pass of the step logic then loads
//  the timer state and the output register together.
//  One transaction per cycle sustained unless the output stalls; state feeds back directly.
//  Output stalls back up only into the input register; cfg is always ready.
//  Reset: phase and mode OAM scan, line 0, display enabled.
// ----------------------------------------------------------------------------
module lcd_line_timing_controller import lltc_pkg::*; #(
  parameter int unsigned LINE_DOTS     = 456,
  parameter int unsigned SCAN_DOTS     = 80,
  parameter int unsigned DRAW_DOTS     = 172,
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned TOTAL_LINES   = 154
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DOT_W-1:0]     dot_count_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LINE_W-1:0]    line_number_o,
  output logic [1:0]           reported_mode_o,
  output logic                 line_match_flag_o,
  output logic                 vblank_irq_o,
  output logic                 status_irq_o,
  output logic                 sprite_scan_pulse_o,
  output logic                 line_render_pulse_o,
  output logic                 frame_done_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic               in_vld_q;
  logic [DOT_W-1:0]   dot_q;
  logic               out_vld_q;
  lltc_result_t       res_q, res_d;
  lltc_state_t        state_q, state_d;
  logic               lcd_en_q;
  logic [LINE_W-1:0]  line_cmp_q;
  logic [IEN_W-1:0]   irq_en_q;
  logic               advance;

  assign advance     = !out_vld_q || out_ready_i;
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_en_q   <= 1'b1;
      line_cmp_q <= '0;
      irq_en_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LCD_ENABLE:   lcd_en_q   <= cfg_data_i[0];
        REG_LINE_COMPARE: line_cmp_q <= cfg_data_i;
        REG_IRQ_ENABLES:  irq_en_q   <= cfg_data_i[IEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      dot_q <= dot_count_i;
    end
  end

  lltc_step #(
    .LINE_DOTS    (LINE_DOTS),
    .SCAN_DOTS    (SCAN_DOTS),
    .DRAW_DOTS    (DRAW_DOTS),
    .VISIBLE_LINES(VISIBLE_LINES),
    .TOTAL_LINES  (TOTAL_LINES)
  ) u_step (
    .cur_i     (state_q),
    .dot_i     (dot_q),
    .lcd_en_i  (lcd_en_q),
    .line_cmp_i(line_cmp_q),
    .irq_en_i  (irq_en_q),
    .nxt_o     (state_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q       <= 1'b0;
      state_q.phase   <= MODE_SCAN;
      state_q.residue <= '0;
      state_q.line    <= '0;
      state_q.mode    <= MODE_SCAN;
      state_q.match   <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign line_number_o       = res_q.line_number;
  assign reported_mode_o     = res_q.reported_mode;
  assign line_match_flag_o   = res_q.line_match_flag;
  assign vblank_irq_o        = res_q.vblank_irq;
  assign status_irq_o        = res_q.status_irq;
  assign sprite_scan_pulse_o = res_q.sprite_scan_pulse;
  assign line_render_pulse_o = res_q.line_render_pulse;
  assign frame_done_o        = res_q.frame_done;

endmodule

// ===== hw/rtl/lltc_checker.sv =====
// ----------------------------------------------------------------------------
// lltc_checker
// Port-level checks for the LCD line timing controller.
// ----------------------------------------------------------------------------
module lltc_checker import lltc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [LINE_W-1:0] line_number_o,
  input logic [1:0]        reported_mode_o,
  input logic              vblank_irq_o,
  input logic              sprite_scan_pulse_o,
  input logic              line_render_pulse_o,
  input logic              frame_done_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_number_o)
      && $stable(reported_mode_o))
    else $error("stalled result changed");

  // v-blank interrupt and frame end come together and land in v-blank
  a_vblank_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (vblank_irq_o || frame_done_o) |->
      vblank_irq_o && frame_done_o && reported_mode_o == MODE_VBLANK)
    else $error("v-blank transaction inconsistent");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sprite_scan_pulse_o |-> reported_mode_o == MODE_DRAW)
    else $error("scan end without drawing mode");

  a_render_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_render_pulse_o |-> reported_mode_o == MODE_HBLANK)
    else $error("render pulse outside h-blank entry");

endmodule

bind lcd_line_timing_controller lltc_checker u_lltc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .line_number_o      (line_number_o),
  .reported_mode_o    (reported_mode_o),
  .vblank_irq_o       (vblank_irq_o),
  .sprite_scan_pulse_o(sprite_scan_pulse_o),
  .line_render_pulse_o(line_render_pulse_o),
  .frame_done_o       (frame_done_o)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lcd_line_timing_controller. A queue of dot-count
// ticks feeds a valid/ready driver; an in-bench timer model predicts the line,
// mode, compare flag and pulses for each accepted tick, and the monitor checks
// every returned transaction against the oldest prediction. Register settings
// and handshake pressure change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import lltc_pkg::*;

  localparam int unsigned LINE_DOTS     = 456;
  localparam int unsigned SCAN_DOTS     = 80;
  localparam int unsigned DRAW_DOTS     = 172;
  localparam int unsigned VISIBLE_LINES = 144;
  localparam int unsigned TOTAL_LINES   = 154;
  localparam int unsigned HBLANK_DOTS   =
      (SCAN_DOTS + DRAW_DOTS >= LINE_DOTS) ? 0 : LINE_DOTS - SCAN_DOTS - DRAW_DOTS;
  localparam int unsigned MAX_DOTS      = 80;
  localparam int unsigned PHASE_TICKS   = 64;
  localparam int unsigned NUM_PHASES    = 16;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [DOT_W-1:0]     dot_count_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [LINE_W-1:0]    line_number_o;
  logic [1:0]           reported_mode_o;
  logic                 line_match_flag_o;
  logic                 vblank_irq_o;
  logic                 status_irq_o;
  logic                 sprite_scan_pulse_o;
  logic                 line_render_pulse_o;
  logic                 frame_done_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i   = '0;

  lcd_line_timing_controller #(
    .LINE_DOTS     (LINE_DOTS),
    .SCAN_DOTS     (SCAN_DOTS),
    .DRAW_DOTS     (DRAW_DOTS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .dot_count_i         (dot_count_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .line_number_o       (line_number_o),
    .reported_mode_o     (reported_mode_o),
    .line_match_flag_o   (line_match_flag_o),
    .vblank_irq_o        (vblank_irq_o),
    .status_irq_o        (status_irq_o),
    .sprite_scan_pulse_o (sprite_scan_pulse_o),
    .line_render_pulse_o (line_render_pulse_o),
    .frame_done_o        (frame_done_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  // Timer model state and its copy of the registers
  mode_e                tmr_phase;
  mode_e                tmr_mode;
  logic [RESIDUE_W-1:0] tmr_residue;
  logic [LINE_W-1:0]    tmr_line;
  logic                 tmr_match;
  logic                 reg_enable;
  logic [LINE_W-1:0]    reg_compare;
  logic [IEN_W-1:0]     reg_irq_en;

  logic [DOT_W-1:0] tick_q[$];
  lltc_result_t     timing_q[$];
  lltc_result_t     want_res;
  int unsigned      error_count    = 0;
  int unsigned      src_idle_pct   = 0;
  int unsigned      sink_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("lcd_line_timing_controller: mismatch");
    $finish;
  end

  function automatic logic enter_phase(input mode_e m);
    tmr_phase = m;
    tmr_mode  = m;
    return (m == MODE_SCAN   && reg_irq_en[IEN_SCAN])   ||
           (m == MODE_VBLANK && reg_irq_en[IEN_VBLANK]) ||
           (m == MODE_HBLANK && reg_irq_en[IEN_HBLANK]);
  endfunction

  function automatic logic compare_line();
    tmr_match = (tmr_line == reg_compare);
    return tmr_match && reg_irq_en[IEN_MATCH];
  endfunction

  function automatic lltc_result_t advance_timer(input logic [DOT_W-1:0] dots);
    int unsigned  acc;
    lltc_result_t res;
    res = '0;
    if (!reg_enable) begin
      // held at line zero; mode and flag are left as they were
      if (tmr_line != 0 || tmr_phase != MODE_VBLANK) begin
        tmr_line    = '0;
        tmr_residue = '0;
        tmr_phase   = MODE_HBLANK;
      end
    end else begin
      acc = tmr_residue + dots;
      case (tmr_phase)
        MODE_SCAN: begin
          if (acc >= SCAN_DOTS) begin
            acc -= SCAN_DOTS;
            res.sprite_scan_pulse = 1'b1;
            res.status_irq |= enter_phase(MODE_DRAW);
          end
        end
        MODE_DRAW: begin
          if (acc >= DRAW_DOTS) begin
            acc -= DRAW_DOTS;
            res.line_render_pulse = (tmr_line < VISIBLE_LINES);
            res.status_irq |= enter_phase(MODE_HBLANK);
          end
        end
        MODE_HBLANK: begin
          if (acc >= HBLANK_DOTS) begin
            acc -= HBLANK_DOTS;
            tmr_line = tmr_line + 1'b1;
            res.status_irq |= compare_line();
            if (tmr_line == VISIBLE_LINES) begin
              res.status_irq |= enter_phase(MODE_VBLANK);
              res.vblank_irq = 1'b1;
              res.frame_done = 1'b1;
            end else begin
              res.status_irq |= enter_phase(MODE_SCAN);
            end
          end
        end
        default: begin
          if (acc >= LINE_DOTS) begin
            acc -= LINE_DOTS;
            tmr_line = tmr_line + 1'b1;
            res.status_irq |= compare_line();
            // frame wrap: compared at the wrap line and again at zero
            if (tmr_line >= TOTAL_LINES) begin
              tmr_line = '0;
              res.status_irq |= compare_line();
              res.status_irq |= enter_phase(MODE_SCAN);
            end
          end
        end
      endcase
      tmr_residue = (acc > 32'hFFFF) ? 16'hFFFF : acc[RESIDUE_W-1:0];
    end
    res.line_number     = tmr_line;
    res.reported_mode   = tmr_mode;
    res.line_match_flag = tmr_match;
    return res;
  endfunction

  // Driver: presents queued ticks, runs the model on each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      dot_count_i <= '0;
      tmr_phase   = MODE_SCAN;
      tmr_mode    = MODE_SCAN;
      tmr_residue = '0;
      tmr_line    = '0;
      tmr_match   = 1'b0;
      reg_enable  = 1'b1;
      reg_compare = '0;
      reg_irq_en  = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_LCD_ENABLE:   reg_enable  = cfg_data_i[0];
          REG_LINE_COMPARE: reg_compare = cfg_data_i[LINE_W-1:0];
          REG_IRQ_ENABLES:  reg_irq_en  = cfg_data_i[IEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) timing_q.push_back(advance_timer(dot_count_i));
      if (!in_valid_i || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_valid_i  <= 1'b1;
          dot_count_i <= tick_q.pop_front();
        end else begin
          in_valid_i  <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      if (error_count < 10)
        $display("%0t: %s expected %0d got %0d", $realtime, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Monitor: checks each returned transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (timing_q.size() == 0) begin
          if (error_count < 10)
            $display("%0t: result with no prediction, line %0d", $realtime, line_number_o);
          error_count++;
        end else begin
          want_res = timing_q.pop_front();
          check_field("line_number", want_res.line_number, line_number_o);
          check_field("reported_mode", want_res.reported_mode, reported_mode_o);
          check_field("line_match_flag", want_res.line_match_flag, line_match_flag_o);
          check_field("vblank_irq", want_res.vblank_irq, vblank_irq_o);
          check_field("status_irq", want_res.status_irq, status_irq_o);
          check_field("sprite_scan_pulse", want_res.sprite_scan_pulse,
                      sprite_scan_pulse_o);
          check_field("line_render_pulse", want_res.line_render_pulse,
                      line_render_pulse_o);
          check_field("frame_done", want_res.frame_done, frame_done_o);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_ticks(input int unsigned dots[]);
    @(negedge clk_i);
    foreach (dots[i]) tick_q.push_back(DOT_W'(dots[i]));
  endtask

  task automatic queue_random(input int unsigned count);
    @(negedge clk_i);
    // mostly long ticks so that whole frames go by
    repeat (count) begin
      if ($urandom_range(0, 9) < 7) tick_q.push_back(DOT_W'($urandom_range(72, MAX_DOTS)));
      else tick_q.push_back(DOT_W'($urandom_range(0, MAX_DOTS)));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || timing_q.size() != 0);
  endtask

  task automatic set_pressure(input int unsigned sel);
    case (sel % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
      default: begin src_idle_pct = 31; sink_stall_pct = 31; end
    endcase
  endtask

  initial begin
    logic [LINE_W-1:0] cmp_val;
    logic [IEN_W-1:0]  ien_val;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Directed: one line through scan, draw, h-blank with a match on line 1
    write_reg(REG_IRQ_ENABLES, 8'hF);
    write_reg(REG_LINE_COMPARE, 8'd1);
    queue_ticks('{0, 80, 63, 64, 80, 80, 80, 80, 80});
    wait_idle();
    // display off mid-line, then resume from h-blank
    write_reg(REG_LCD_ENABLE, 8'd0);
    queue_ticks('{42, 80, 0, 17});
    wait_idle();
    write_reg(REG_LCD_ENABLE, 8'd1);
    write_reg(REG_LINE_COMPARE, 8'd0);
    write_reg(REG_IRQ_ENABLES, 8'd1);
    queue_ticks('{80, 80, 44, 80});
    wait_idle();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      set_pressure(ph);
      if (tmr_line >= 120) begin
        // near the frame end: hit the wrap line or line zero
        cmp_val = $urandom_range(0, 1) ? 8'(TOTAL_LINES) : 8'd0;
        ien_val = 4'($urandom_range(0, 15)) | 4'(1 << IEN_MATCH);
      end else begin
        case ($urandom_range(0, 3))
          0:       cmp_val = 8'hFF;
          1:       cmp_val = 8'($urandom_range(0, 255));
          default: cmp_val = tmr_line + 8'($urandom_range(1, 20));
        endcase
        ien_val = 4'($urandom_range(0, 15));
      end
      if (ph == 0) begin
        cmp_val = 8'hFF;
        ien_val = '0;
      end else if (ph == 1) begin
        ien_val = 4'hF;
      end
      write_reg(REG_LINE_COMPARE, cmp_val);
      write_reg(REG_IRQ_ENABLES, 8'(ien_val));
      queue_random(PHASE_TICKS);
      wait_idle();
    end

    set_pressure(3);
    write_reg(REG_LCD_ENABLE, 8'd0);
    queue_random(20);
    wait_idle();
    set_pressure(0);
    write_reg(REG_LCD_ENABLE, 8'd1);
    queue_random(40);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (error_count == 0 && timing_q.size() == 0) begin
      $display("lcd_line_timing_controller: match");
    end else begin
      $display("lcd_line_timing_controller: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lltc_pkg.sv
hw/rtl/lltc_step.sv
hw/rtl/lcd_line_timing_controller.sv
hw/rtl/lltc_checker.sv
dv/testbench.sv
